### design/bps_pkg.sv
package bps_pkg;

   // smallest nonzero on, off or pause duration in ticks
   localparam int MinInterval = 10;

   localparam int DurW    = 16;   // duration registers
   localparam int FreqW   = 16;   // tone frequency
   localparam int BeepsW  = 8;    // beeps per sequence
   localparam int CountW  = 16;   // sequence count and sequences done
   localparam int BlinkW  = DurW + 1;           // on + off
   localparam int SeqW    = BlinkW + BeepsW;    // length of a sequence
   localparam int CsrIdxW = 3;
   localparam int CsrDataW = 16;

   // register map
   typedef enum logic [CsrIdxW-1:0] {
      REG_TONE_FREQUENCY     = 3'd0,
      REG_ON_DURATION        = 3'd1,
      REG_OFF_DURATION       = 3'd2,
      REG_BEEPS_PER_SEQUENCE = 3'd3,
      REG_PAUSE_DURATION     = 3'd4,
      REG_SEQUENCE_COUNT     = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [FreqW-1:0]  tone_frequency;
      logic [DurW-1:0]   on_duration;
      logic [DurW-1:0]   off_duration;
      logic [BeepsW-1:0] beeps_per_sequence;
      logic [DurW-1:0]   pause_duration;
      logic [CountW-1:0] sequence_count;
   } cfg_type;

   typedef struct packed {
      logic             tone_on;
      logic [FreqW-1:0] tone_freq_out;
      logic             finished;
      logic             running;
   } rsp_type;

   // nonzero durations below the minimum are raised to it, zero stays zero
   function automatic logic [DurW-1:0] raise_min(input logic [DurW-1:0] d,
                                                 input logic [DurW-1:0] floor_val);
      if (d == '0) begin
         return '0;
      end
      return (d < floor_val) ? floor_val : d;
   endfunction

endpackage

### design/bps_if.sv
// tick channel: one item per millisecond tick
interface bps_req_if;
   logic valid;
   logic ready;
   logic start_req;
   logic stop;

   modport source (output valid, output start_req, output stop, input ready);
   modport sink   (input valid, input start_req, input stop, output ready);
endinterface

// result channel: one item per tick
interface bps_rsp_if import bps_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             tone_on;
   logic [FreqW-1:0] tone_freq_out;
   logic             finished;
   logic             running;

   modport source (output valid, output tone_on, output tone_freq_out,
                   output finished, output running, input ready);
   modport sink   (input valid, input tone_on, input tone_freq_out,
                   input finished, input running, output ready);
endinterface

### design/bps_csr.sv
module bps_csr import bps_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_en,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_write_data,
   output cfg_type             cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // decode the write; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            REG_TONE_FREQUENCY:     cfg_in.tone_frequency = csr_write_data;
            REG_ON_DURATION:        cfg_in.on_duration    = csr_write_data;
            REG_OFF_DURATION:       cfg_in.off_duration   = csr_write_data;
            REG_BEEPS_PER_SEQUENCE: cfg_in.beeps_per_sequence = csr_write_data[BeepsW-1:0];
            REG_PAUSE_DURATION:     cfg_in.pause_duration = csr_write_data;
            REG_SEQUENCE_COUNT:     cfg_in.sequence_count = csr_write_data;
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tone_frequency     <= '0;
         cfg_ff.on_duration        <= '0;
         cfg_ff.off_duration       <= '0;
         cfg_ff.beeps_per_sequence <= BeepsW'(1);
         cfg_ff.pause_duration     <= '0;
         cfg_ff.sequence_count     <= CountW'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### design/bps_engine.sv
module bps_engine import bps_pkg::*; #(
   parameter int MIN_INTERVAL = MinInterval
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  logic    start_req,
   input  logic    stop,
   input  cfg_type cfg,
   output rsp_type result
);

   localparam logic [DurW-1:0] MinDur = DurW'(MIN_INTERVAL);

   logic              active_ff, active_in;
   logic [SeqW-1:0]   time_in_sequence_ff, time_in_sequence_in;
   logic [BlinkW-1:0] time_in_beep_ff, time_in_beep_in;
   logic [CountW-1:0] sequences_done_ff, sequences_done_in;

   logic [DurW-1:0]   on_eff, off_eff, pause_eff;
   logic [BlinkW-1:0] blink;
   logic [SeqW-1:0]   blinking;
   logic [SeqW-1:0]   seq_len;

   logic              start_tick;
   logic              act0;
   logic [SeqW-1:0]   tis0;
   logic [BlinkW-1:0] tib0;
   logic [CountW-1:0] done0;
   logic [SeqW:0]     tis_inc;
   logic [BlinkW:0]   tib_inc;
   logic              count_met;
   logic              tone;
   logic              fin;

   // effective timing from the registers
   assign on_eff    = raise_min(cfg.on_duration, MinDur);
   assign off_eff   = raise_min(cfg.off_duration, MinDur);
   assign pause_eff = raise_min(cfg.pause_duration, MinDur);
   assign blink     = {1'b0, on_eff} + {1'b0, off_eff};
   assign blinking  = SeqW'(blink) * SeqW'(cfg.beeps_per_sequence);
   assign seq_len   = (cfg.beeps_per_sequence == '0) ? SeqW'(pause_eff)
                    : blinking - SeqW'(off_eff) + SeqW'(pause_eff);

   // stop wins over start; start restarts from time zero
   assign start_tick = !stop && start_req;
   assign act0  = stop ? 1'b0 : (start_req ? 1'b1 : active_ff);
   assign tis0  = start_tick ? '0 : time_in_sequence_ff;
   assign tib0  = start_tick ? '0 : time_in_beep_ff;
   assign done0 = start_tick ? '0 : sequences_done_ff;

   assign tis_inc   = {1'b0, tis0} + (SeqW+1)'(1);
   assign tib_inc   = {1'b0, tib0} + (BlinkW+1)'(1);
   assign count_met = (cfg.sequence_count != '0) && (done0 >= cfg.sequence_count);

   // one tick of the pattern
   always_comb begin
      active_in           = act0;
      time_in_sequence_in = tis0;
      time_in_beep_in     = tib0;
      sequences_done_in   = done0;
      tone                = 1'b0;
      fin                 = 1'b0;
      if (act0) begin
         if ((seq_len == '0) || count_met) begin
            active_in = 1'b0;
            fin       = 1'b1;
         end else begin
            tone = (tis0 < blinking) && (tib0 < {1'b0, on_eff});
            time_in_beep_in = (tib_inc >= {1'b0, blink}) ? '0 : tib_inc[BlinkW-1:0];
            if (tis_inc >= {1'b0, seq_len}) begin
               time_in_sequence_in = '0;
               time_in_beep_in     = '0;
               if (done0 != '1) begin
                  sequences_done_in = done0 + CountW'(1);
               end
            end else begin
               time_in_sequence_in = tis_inc[SeqW-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff           <= 1'b0;
         time_in_sequence_ff <= '0;
         time_in_beep_ff     <= '0;
         sequences_done_ff   <= '0;
      end else if (step) begin
         active_ff           <= active_in;
         time_in_sequence_ff <= time_in_sequence_in;
         time_in_beep_ff     <= time_in_beep_in;
         sequences_done_ff   <= sequences_done_in;
      end
   end

   assign result.tone_on       = tone;
   assign result.tone_freq_out = cfg.tone_frequency;
   assign result.finished      = fin;
   assign result.running       = active_in;

   // checks
   a_fin_not_running: assert property (@(posedge clock) disable iff (reset)
      step && result.finished |-> !result.running)
      else $error("finished item still reports running");

   a_tone_running: assert property (@(posedge clock) disable iff (reset)
      step && result.tone_on |-> result.running)
      else $error("tone on without an active pattern");

   a_stop_ends: assert property (@(posedge clock) disable iff (reset)
      step && stop |=> !active_ff)
      else $error("pattern still active after stop");

   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      step && start_req && !stop |=> sequences_done_ff == '0)
      else $error("sequence count not cleared by start");

endmodule

### design/beep_pattern_sequencer.sv
// Flow: an accepted item waits in the input register, and its result is registered for rsp_chan.
// Throughput: one item per cycle while rsp_chan is ready; the input register and the result register
// advance together, so a new tick is taken in the cycle the waiting result is taken.
// Reset: synchronous, active high; clears the handshake valids, the pattern
// state and sets the registers to their reset values (beeps and count to one).
module beep_pattern_sequencer import bps_pkg::*; #(
   parameter int MIN_INTERVAL = MinInterval
) (
   input  logic                clock,
   input  logic                reset,
   bps_req_if.sink             req_chan,
   bps_rsp_if.source           rsp_chan,
   input  logic                csr_write_en,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_write_data
);

   cfg_type cfg;
   rsp_type result;

   logic    in_valid_ff, in_valid_in;
   logic    in_start_ff, in_start_in;
   logic    in_stop_ff, in_stop_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic    out_free;
   logic    step;
   logic    req_take;

   bps_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .cfg            (cfg)
   );

   bps_engine #(.MIN_INTERVAL(MIN_INTERVAL)) u_engine (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .start_req (in_start_ff),
      .stop      (in_stop_ff),
      .cfg       (cfg),
      .result    (result)
   );

   // flow control: the item in the input register moves on when the result slot frees
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign step           = in_valid_ff && out_free;
   assign req_chan.ready = !in_valid_ff || out_free;
   assign req_take       = req_chan.valid && req_chan.ready;

   assign in_valid_in  = req_take || (in_valid_ff && !step);
   assign in_start_in  = req_take ? req_chan.start_req : in_start_ff;
   assign in_stop_in   = req_take ? req_chan.stop : in_stop_ff;
   assign rsp_valid_in = step || (rsp_valid_ff && !rsp_chan.ready);
   assign rsp_data_in  = step ? result : rsp_data_ff;

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      in_start_ff <= in_start_in;
      in_stop_ff  <= in_stop_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.tone_on       = rsp_data_ff.tone_on;
   assign rsp_chan.tone_freq_out = rsp_data_ff.tone_freq_out;
   assign rsp_chan.finished      = rsp_data_ff.finished;
   assign rsp_chan.running       = rsp_data_ff.running;

endmodule
